// ===== hw/rtl/imgrot_pkg.sv =====
// Shared constants and types for the nearest-neighbor image rotation block.
package imgrot_pkg;

  // Default geometry and fixed-point format
  localparam int DEF_MAX_ROWS  = 128;
  localparam int DEF_MAX_COLS  = 128;
  localparam int DEF_FRAC_BITS = 14;

  // Field widths fixed by the interface
  localparam int ANGLE_W = 16;
  localparam int DIM_W   = 8;
  localparam int SRC_W   = 7;
  localparam int OUT_W   = 9;
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 4 * CHAN_W;
  localparam int CFG_AW  = 2;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_COS  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_SIN  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_ROWS = 2'd2;
  localparam logic [CFG_AW-1:0] REG_COLS = 2'd3;

  // Register reset values
  localparam logic [ANGLE_W-1:0] COS_RST  = 16'h4000;
  localparam logic [ANGLE_W-1:0] SIN_RST  = 16'h0000;
  localparam logic [DIM_W-1:0]   ROWS_RST = 8'd128;
  localparam logic [DIM_W-1:0]   COLS_RST = 8'd128;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Fill color for positions that map outside the source
  localparam logic [CHAN_W-1:0] FILL_COLOR = 8'd255;
  localparam logic [CHAN_W-1:0] FILL_ALPHA = 8'd0;

  // Output size saturates here
  localparam logic [OUT_W-1:0] SIZE_MAX = 9'd511;

  // Cycles for the bounding box pipeline to follow a register write
  localparam int SETTLE_CYC = 4;
  localparam int SETTLE_W   = 3;

  // Read-item sequencer
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ADDR = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_MAP  = 6'b001000,
    ST_READ = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

endpackage

// ===== hw/rtl/image_rotate_nearest.sv =====
// Top level: pixel store plus inverse-mapping rotation with ceiling pick.
//
//   channel | direction | handshake           | beat contents
//   in_     | input     | in_valid/in_ready   | kind, source address, output address, RGBA
//   out_    | output    | out_valid/out_ready | RGBA, outside flag, output image size
//   cfg_    | input     | cfg_we              | register index and data, no wait
//
// A write beat is one store write. A read beat goes from accept to result register
// through offset add, four 16-bit by 26-bit multiplies, ceiling sum, one store read
// and result load; in_ready returns once the result is loaded, so the sequencer
// holds one read at a time and takes no new beat until that read is done.
// After reset and after each register write, in_ready stays low while the bounding
// box pipeline settles. The store is not cleared.
// A stalled result register blocks the sequencer only at its last step.
module image_rotate_nearest #(
  parameter int MAX_ROWS  = imgrot_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS  = imgrot_pkg::DEF_MAX_COLS,
  parameter int FRAC_BITS = imgrot_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [imgrot_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [imgrot_pkg::ANGLE_W-1:0]     cfg_wdata,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_kind,
  input  logic [imgrot_pkg::SRC_W-1:0]       in_src_row,
  input  logic [imgrot_pkg::SRC_W-1:0]       in_src_col,
  input  logic [imgrot_pkg::OUT_W-1:0]       in_out_row,
  input  logic [imgrot_pkg::OUT_W-1:0]       in_out_col,
  input  logic [imgrot_pkg::CHAN_W-1:0]      in_red_in,
  input  logic [imgrot_pkg::CHAN_W-1:0]      in_green_in,
  input  logic [imgrot_pkg::CHAN_W-1:0]      in_blue_in,
  input  logic [imgrot_pkg::CHAN_W-1:0]      in_alpha_in,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [imgrot_pkg::CHAN_W-1:0]      out_red_out,
  output logic [imgrot_pkg::CHAN_W-1:0]      out_green_out,
  output logic [imgrot_pkg::CHAN_W-1:0]      out_blue_out,
  output logic [imgrot_pkg::CHAN_W-1:0]      out_alpha_out,
  output logic                               out_outside,
  output logic [imgrot_pkg::OUT_W-1:0]       out_result_rows,
  output logic [imgrot_pkg::OUT_W-1:0]       out_result_cols
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = MAX_ROWS * (1 << CW);
  localparam int XW    = (RW > CW) ? RW : CW;
  localparam int DW    = (XW + 1 > imgrot_pkg::DIM_W) ? XW + 1 : imgrot_pkg::DIM_W;
  localparam int PW    = XW + 1 + imgrot_pkg::ANGLE_W;   // corner product
  localparam int BW    = PW + 1;                         // corner sums
  localparam int SHW   = imgrot_pkg::OUT_W + FRAC_BITS + 1;
  localparam int OW    = ((SHW > BW) ? SHW : BW) + 1;    // offset output position
  localparam int MW    = OW + imgrot_pkg::ANGLE_W;       // mapping product
  localparam int TW    = MW + 2;                         // mapping sum
  localparam int SW    = TW - 2 * FRAC_BITS;             // mapped source position
  localparam int KW    = ((SW > XW + 1) ? SW : XW + 1);  // bounds compare
  localparam logic signed [TW-1:0] CEIL_MAP =
    {{(TW - 2 * FRAC_BITS){1'b0}}, {(2 * FRAC_BITS){1'b1}}};
  localparam logic [BW:0] CEIL_SIZE = {{(BW + 1 - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

  // ---------------------------------------------------------------- config
  logic signed [imgrot_pkg::ANGLE_W-1:0] cs_r, sn_r;
  logic [imgrot_pkg::DIM_W-1:0]          rows_r, cols_r;
  logic [imgrot_pkg::SETTLE_W-1:0]       settle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r     <= imgrot_pkg::COS_RST;
      sn_r     <= imgrot_pkg::SIN_RST;
      rows_r   <= imgrot_pkg::ROWS_RST;
      cols_r   <= imgrot_pkg::COLS_RST;
      settle_r <= imgrot_pkg::SETTLE_W'(imgrot_pkg::SETTLE_CYC);
    end else begin
      if (cfg_we) begin
        settle_r <= imgrot_pkg::SETTLE_W'(imgrot_pkg::SETTLE_CYC);
        case (cfg_addr)
          imgrot_pkg::REG_COS:  cs_r   <= cfg_wdata;
          imgrot_pkg::REG_SIN:  sn_r   <= cfg_wdata;
          imgrot_pkg::REG_ROWS: rows_r <= cfg_wdata[imgrot_pkg::DIM_W-1:0];
          imgrot_pkg::REG_COLS: cols_r <= cfg_wdata[imgrot_pkg::DIM_W-1:0];
          default: ;
        endcase
      end else if (settle_r != '0) begin
        settle_r <= settle_r - imgrot_pkg::SETTLE_W'(1);
      end
    end
  end

  // ------------------------------------------------ bounding box pipeline
  // stage 1: clamp dimensions
  logic [imgrot_pkg::DIM_W-1:0] rows_min1, cols_min1;
  logic [RW:0] nr_r, nr_nxt;
  logic [CW:0] nc_r, nc_nxt;

  always_comb begin
    rows_min1 = (rows_r == '0) ? imgrot_pkg::DIM_W'(1) : rows_r;
    cols_min1 = (cols_r == '0) ? imgrot_pkg::DIM_W'(1) : cols_r;
    nr_nxt = (DW'(rows_min1) > DW'(MAX_ROWS)) ? (RW + 1)'(MAX_ROWS) : (RW + 1)'(rows_min1);
    nc_nxt = (DW'(cols_min1) > DW'(MAX_COLS)) ? (CW + 1)'(MAX_COLS) : (CW + 1)'(cols_min1);
  end

  // stage 2: corner products
  logic [XW-1:0] nr1, nc1;
  logic signed [PW-1:0] a_r, b_r, c_r, d_r;   // nr1*cs, nc1*sn, nr1*sn, nc1*cs

  assign nr1 = XW'(nr_r - (RW + 1)'(1));
  assign nc1 = XW'(nc_r - (CW + 1)'(1));

  // stage 3: minima and spans; min and max over corners split per term
  logic signed [PW-1:0] a_neg, b_neg, nc_neg, d_neg;
  logic [PW-1:0]        a_abs, b_abs, c_abs, d_abs;
  logic signed [BW-1:0] rmin_r, cmin_r;
  logic [BW-1:0]        rspan_r, cspan_r;

  always_comb begin
    a_neg  = a_r[PW-1] ? a_r : '0;
    b_neg  = b_r[PW-1] ? b_r : '0;
    nc_neg = c_r[PW-1] ? '0 : -c_r;
    d_neg  = d_r[PW-1] ? d_r : '0;
    a_abs  = a_r[PW-1] ? PW'(-a_r) : PW'(a_r);
    b_abs  = b_r[PW-1] ? PW'(-b_r) : PW'(b_r);
    c_abs  = c_r[PW-1] ? PW'(-c_r) : PW'(c_r);
    d_abs  = d_r[PW-1] ? PW'(-d_r) : PW'(d_r);
  end

  // stage 4: output size, ceiling and saturation
  logic [BW:0] rsz_t, csz_t, rsz_q, csz_q;
  logic [imgrot_pkg::OUT_W-1:0] rsize_r, csize_r;

  always_comb begin
    rsz_t = {1'b0, rspan_r} + CEIL_SIZE;
    csz_t = {1'b0, cspan_r} + CEIL_SIZE;
    rsz_q = rsz_t >> FRAC_BITS;
    csz_q = csz_t >> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    nr_r    <= nr_nxt;
    nc_r    <= nc_nxt;
    a_r     <= PW'($signed({1'b0, nr1}) * cs_r);
    b_r     <= PW'($signed({1'b0, nc1}) * sn_r);
    c_r     <= PW'($signed({1'b0, nr1}) * sn_r);
    d_r     <= PW'($signed({1'b0, nc1}) * cs_r);
    rmin_r  <= BW'(a_neg) + BW'(b_neg);
    cmin_r  <= BW'(nc_neg) + BW'(d_neg);
    rspan_r <= BW'(a_abs) + BW'(b_abs);
    cspan_r <= BW'(c_abs) + BW'(d_abs);
    rsize_r <= (rsz_q > (BW + 1)'(imgrot_pkg::SIZE_MAX)) ? imgrot_pkg::SIZE_MAX
                                                          : imgrot_pkg::OUT_W'(rsz_q);
    csize_r <= (csz_q > (BW + 1)'(imgrot_pkg::SIZE_MAX)) ? imgrot_pkg::SIZE_MAX
                                                          : imgrot_pkg::OUT_W'(csz_q);
  end

  // ------------------------------------------------------ read sequencer
  imgrot_pkg::state_t state_r, state_nxt;
  logic in_acc, out_load, out_valid_r;

  assign in_ready = (state_r == imgrot_pkg::ST_IDLE) && (settle_r == '0);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state_r == imgrot_pkg::ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      imgrot_pkg::ST_IDLE:
        if (in_acc && in_kind == imgrot_pkg::KIND_READ) state_nxt = imgrot_pkg::ST_ADDR;
      imgrot_pkg::ST_ADDR: state_nxt = imgrot_pkg::ST_MUL;
      imgrot_pkg::ST_MUL:  state_nxt = imgrot_pkg::ST_MAP;
      imgrot_pkg::ST_MAP:  state_nxt = imgrot_pkg::ST_READ;
      imgrot_pkg::ST_READ: state_nxt = imgrot_pkg::ST_DONE;
      imgrot_pkg::ST_DONE:
        if (out_load) state_nxt = imgrot_pkg::ST_IDLE;
      default: state_nxt = imgrot_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= imgrot_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // mapping datapath
  logic [imgrot_pkg::OUT_W-1:0] orow_q_r, ocol_q_r;
  logic signed [OW-1:0] orow_r, ocol_r;
  logic signed [MW-1:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [TW-1:0] tr, tc;
  logic signed [SW-1:0] sr_r, sc_r;
  logic [KW-1:0]        sr_k, sc_k;
  logic                 inside_nxt, inside_r;

  always_comb begin
    tr = TW'(p0_r) - TW'(p1_r) + CEIL_MAP;
    tc = TW'(p2_r) + TW'(p3_r) + CEIL_MAP;
    sr_k = KW'($unsigned(sr_r));
    sc_k = KW'($unsigned(sc_r));
    inside_nxt = !sr_r[SW-1] && !sc_r[SW-1] &&
                 (sr_k < KW'(nr_r)) && (sc_k < KW'(nc_r));
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      orow_q_r <= in_out_row;
      ocol_q_r <= in_out_col;
    end
    if (state_r == imgrot_pkg::ST_ADDR) begin
      orow_r <= $signed(OW'({orow_q_r, {FRAC_BITS{1'b0}}})) + OW'(rmin_r);
      ocol_r <= $signed(OW'({ocol_q_r, {FRAC_BITS{1'b0}}})) + OW'(cmin_r);
    end
    if (state_r == imgrot_pkg::ST_MUL) begin
      p0_r <= MW'(orow_r * cs_r);
      p1_r <= MW'(ocol_r * sn_r);
      p2_r <= MW'(orow_r * sn_r);
      p3_r <= MW'(ocol_r * cs_r);
    end
    if (state_r == imgrot_pkg::ST_MAP) begin
      sr_r <= tr[TW-1:2*FRAC_BITS];
      sc_r <= tc[TW-1:2*FRAC_BITS];
    end
    if (state_r == imgrot_pkg::ST_READ) inside_r <= inside_nxt;
  end

  // ---------------------------------------------------------- pixel store
  logic [imgrot_pkg::PIX_W-1:0] mem [DEPTH];
  logic [imgrot_pkg::PIX_W-1:0] mem_q_r;
  logic          mem_we, mem_re;
  logic [AW-1:0] wr_addr, rd_addr;

  assign mem_we  = in_acc && (in_kind == imgrot_pkg::KIND_WRITE) &&
                   (32'(in_src_row) < 32'(MAX_ROWS)) && (32'(in_src_col) < 32'(MAX_COLS));
  assign wr_addr = {RW'(in_src_row), CW'(in_src_col)};
  assign mem_re  = (state_r == imgrot_pkg::ST_READ);
  assign rd_addr = {RW'(sr_k), CW'(sc_k)};

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= {in_red_in, in_green_in, in_blue_in, in_alpha_in};
    if (mem_re) mem_q_r <= mem[rd_addr];
  end

  // ------------------------------------------------------ result register
  logic [imgrot_pkg::CHAN_W-1:0] red_r, green_r, blue_r, alpha_r;
  logic                          outside_r;
  logic [imgrot_pkg::OUT_W-1:0]  rows_out_r, cols_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (inside_r) begin
        red_r   <= mem_q_r[4*imgrot_pkg::CHAN_W-1:3*imgrot_pkg::CHAN_W];
        green_r <= mem_q_r[3*imgrot_pkg::CHAN_W-1:2*imgrot_pkg::CHAN_W];
        blue_r  <= mem_q_r[2*imgrot_pkg::CHAN_W-1:imgrot_pkg::CHAN_W];
        alpha_r <= mem_q_r[imgrot_pkg::CHAN_W-1:0];
      end else begin
        red_r   <= imgrot_pkg::FILL_COLOR;
        green_r <= imgrot_pkg::FILL_COLOR;
        blue_r  <= imgrot_pkg::FILL_COLOR;
        alpha_r <= imgrot_pkg::FILL_ALPHA;
      end
      outside_r  <= !inside_r;
      rows_out_r <= rsize_r;
      cols_out_r <= csize_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_out     = red_r;
  assign out_green_out   = green_r;
  assign out_blue_out    = blue_r;
  assign out_alpha_out   = alpha_r;
  assign out_outside     = outside_r;
  assign out_result_rows = rows_out_r;
  assign out_result_cols = cols_out_r;

  // ------------------------------------------------------------ assertions
  // a register write closes the input until the bounding box has settled
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input accepted right after a register write");

  // the store is never written and read in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("store write and read overlap");

  // an accepted read beat starts the mapping sequence
  a_read_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind == imgrot_pkg::KIND_READ) |=> state_r == imgrot_pkg::ST_ADDR)
    else $error("read beat did not start the sequencer");

  // a result that lies outside carries the fill color
  a_outside_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_outside) |->
      (out_alpha_out == imgrot_pkg::FILL_ALPHA && out_red_out == imgrot_pkg::FILL_COLOR))
    else $error("outside result without fill color");

endmodule

// ===== tb/testbench.sv =====
// Testbench for image_rotate_nearest: random pixel loads and rotated reads, checked per beat.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC        = imgrot_pkg::DEF_FRAC_BITS;
  localparam int NROWS_MAX   = imgrot_pkg::DEF_MAX_ROWS;
  localparam int NCOLS_MAX   = imgrot_pkg::DEF_MAX_COLS;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYC    = 400;
  localparam int DRAIN_CYC   = 12;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int RASTER_CAP  = 40;

  // One input beat; rgba packs red, green, blue, alpha from the top down
  typedef struct packed {
    logic                         kind;
    logic [imgrot_pkg::SRC_W-1:0] src_row;
    logic [imgrot_pkg::SRC_W-1:0] src_col;
    logic [imgrot_pkg::OUT_W-1:0] out_row;
    logic [imgrot_pkg::OUT_W-1:0] out_col;
    logic [imgrot_pkg::PIX_W-1:0] rgba;
  } pix_beat_t;

  // One result beat
  typedef struct packed {
    logic [imgrot_pkg::PIX_W-1:0] rgba;
    logic                         outside;
    logic [imgrot_pkg::OUT_W-1:0] height;
    logic [imgrot_pkg::OUT_W-1:0] width;
  } pix_result_t;

  // Where an output pixel lands in the source, plus the output size
  typedef struct packed {
    logic                         landed;
    logic [imgrot_pkg::SRC_W-1:0] row;
    logic [imgrot_pkg::SRC_W-1:0] col;
    logic [imgrot_pkg::OUT_W-1:0] height;
    logic [imgrot_pkg::OUT_W-1:0] width;
  } src_hit_t;

  typedef enum logic [1:0] {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} pace_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           cfg_we    = 1'b0;
  logic [imgrot_pkg::CFG_AW-1:0]  cfg_addr  = '0;
  logic [imgrot_pkg::ANGLE_W-1:0] cfg_wdata = '0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  pix_beat_t                      beat_cur  = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [imgrot_pkg::CHAN_W-1:0]  out_red, out_green, out_blue, out_alpha;
  logic                           out_outside;
  logic [imgrot_pkg::OUT_W-1:0]   out_rows, out_cols;
  pix_result_t                    seen;

  // Register shadows used by the predictor
  logic signed [imgrot_pkg::ANGLE_W-1:0] cos_set  = imgrot_pkg::COS_RST;
  logic signed [imgrot_pkg::ANGLE_W-1:0] sin_set  = imgrot_pkg::SIN_RST;
  logic [imgrot_pkg::DIM_W-1:0]          rows_set = imgrot_pkg::ROWS_RST;
  logic [imgrot_pkg::DIM_W-1:0]          cols_set = imgrot_pkg::COLS_RST;

  logic [imgrot_pkg::PIX_W-1:0] src_image   [NROWS_MAX*NCOLS_MAX];
  bit               gen_written [NROWS_MAX*NCOLS_MAX];
  pix_beat_t        beats_pending[$];
  pix_result_t      pixels_due[$];
  int unsigned      err_cnt   = 0;
  int unsigned      cycle_cnt = 0;
  int unsigned      queued    = 0;
  pace_t            pace      = PACE_SLOW_SINK;
  bit               hold_go   = 1'b0;
  logic             hold_off  = 1'b0;

  image_rotate_nearest u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (beat_cur.kind),
    .in_src_row      (beat_cur.src_row),
    .in_src_col      (beat_cur.src_col),
    .in_out_row      (beat_cur.out_row),
    .in_out_col      (beat_cur.out_col),
    .in_red_in       (beat_cur.rgba[31:24]),
    .in_green_in     (beat_cur.rgba[23:16]),
    .in_blue_in      (beat_cur.rgba[15:8]),
    .in_alpha_in     (beat_cur.rgba[7:0]),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red_out     (out_red),
    .out_green_out   (out_green),
    .out_blue_out    (out_blue),
    .out_alpha_out   (out_alpha),
    .out_outside     (out_outside),
    .out_result_rows (out_rows),
    .out_result_cols (out_cols)
  );

  assign seen = {out_red, out_green, out_blue, out_alpha, out_outside, out_rows, out_cols};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ceil(v / 2^s), negative values handled without shifting them
  function automatic longint ceil_shift(input longint v, input int s);
    if (v >= 0) return (v + (longint'(1) << s) - 1) >>> s;
    return -((-v) >>> s);
  endfunction

  // Size registers: 0 acts as 1, anything above the store acts as its size
  function automatic longint clamp_dim(input logic [imgrot_pkg::DIM_W-1:0] v, input int lim);
    if (v == 0) return 1;
    if (int'(v) > lim) return longint'(lim);
    return longint'(v);
  endfunction

  // Back-map an output pixel through the current angle and source size
  function automatic src_hit_t rotate_lookup(input logic [imgrot_pkg::OUT_W-1:0] orow_i,
                                             input logic [imgrot_pkg::OUT_W-1:0] ocol_i);
    longint   cs, sn, nr, nc, r, c, pr, pc;
    longint   rmin, rmax, cmin, cmax, orow, ocol, sr, sc, h, w;
    int       k;
    src_hit_t hit;
    cs   = longint'(cos_set);
    sn   = longint'(sin_set);
    nr   = clamp_dim(rows_set, NROWS_MAX);
    nc   = clamp_dim(cols_set, NCOLS_MAX);
    rmin = 0;
    rmax = 0;
    cmin = 0;
    cmax = 0;
    // rotated corners; the origin stays inside the box
    for (k = 0; k < 4; k++) begin
      r  = k[1] ? nr - 1 : 0;
      c  = k[0] ? nc - 1 : 0;
      pr = r * cs + c * sn;
      pc = c * cs - r * sn;
      if (pr < rmin) rmin = pr;
      if (pr > rmax) rmax = pr;
      if (pc < cmin) cmin = pc;
      if (pc > cmax) cmax = pc;
    end
    h = ceil_shift(rmax - rmin, FRAC);
    w = ceil_shift(cmax - cmin, FRAC);
    hit.height = (h > longint'(imgrot_pkg::SIZE_MAX)) ? imgrot_pkg::SIZE_MAX
                                                      : h[imgrot_pkg::OUT_W-1:0];
    hit.width  = (w > longint'(imgrot_pkg::SIZE_MAX)) ? imgrot_pkg::SIZE_MAX
                                                      : w[imgrot_pkg::OUT_W-1:0];
    // position carries 2*FRAC fraction bits, rounded up
    orow = longint'(orow_i) * (longint'(1) << FRAC) + rmin;
    ocol = longint'(ocol_i) * (longint'(1) << FRAC) + cmin;
    sr   = ceil_shift(orow * cs - ocol * sn, 2 * FRAC);
    sc   = ceil_shift(orow * sn + ocol * cs, 2 * FRAC);
    hit.landed = (sr >= 0) && (sr < nr) && (sc >= 0) && (sc < nc);
    hit.row    = sr[imgrot_pkg::SRC_W-1:0];
    hit.col    = sc[imgrot_pkg::SRC_W-1:0];
    return hit;
  endfunction

  // Update the source image or queue the pixel a read should return
  function automatic void apply_beat(input pix_beat_t b);
    src_hit_t    hit;
    pix_result_t res;
    if (b.kind == imgrot_pkg::KIND_WRITE) begin
      src_image[{b.src_row, b.src_col}] = b.rgba;
      return;
    end
    hit = rotate_lookup(b.out_row, b.out_col);
    res.rgba    = hit.landed ? src_image[{hit.row, hit.col}]
                             : {imgrot_pkg::FILL_COLOR, imgrot_pkg::FILL_COLOR,
                                imgrot_pkg::FILL_COLOR, imgrot_pkg::FILL_ALPHA};
    res.outside = !hit.landed;
    res.height  = hit.height;
    res.width   = hit.width;
    pixels_due.push_back(res);
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    err_cnt++;
    if (err_cnt <= 40) $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  task automatic check_pixel(input pix_result_t got);
    pix_result_t want;
    if (pixels_due.size() == 0) begin
      flag_mismatch("result beat with nothing due, rgba", got.rgba, 0);
      return;
    end
    want = pixels_due.pop_front();
    if (got.rgba[31:24] !== want.rgba[31:24])
      flag_mismatch("red", got.rgba[31:24], want.rgba[31:24]);
    if (got.rgba[23:16] !== want.rgba[23:16])
      flag_mismatch("green", got.rgba[23:16], want.rgba[23:16]);
    if (got.rgba[15:8] !== want.rgba[15:8])
      flag_mismatch("blue", got.rgba[15:8], want.rgba[15:8]);
    if (got.rgba[7:0] !== want.rgba[7:0])
      flag_mismatch("alpha", got.rgba[7:0], want.rgba[7:0]);
    if (got.outside !== want.outside) flag_mismatch("outside", got.outside, want.outside);
    if (got.height !== want.height) flag_mismatch("result_rows", got.height, want.height);
    if (got.width !== want.width) flag_mismatch("result_cols", got.width, want.width);
  endtask

  function automatic bit source_gap();
    case (pace)
      PACE_SLOW_SINK:   return $urandom_range(99) < 28;
      PACE_SLOW_SOURCE: return $urandom_range(99) < 54;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic bit sink_stall();
    case (pace)
      PACE_SLOW_SINK:   return $urandom_range(99) < 54;
      PACE_SLOW_SOURCE: return $urandom_range(99) < 28;
      default:          return 1'b0;
    endcase
  endfunction

  // Driver: predict on accept, then offer the next pending beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_beat(beat_cur);
      if (!in_valid || in_ready) begin
        if (beats_pending.size() != 0 && !source_gap()) begin
          beat_cur <= beats_pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat, stall at random or during the hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_pixel(seen);
      out_ready <= !hold_off && !sink_stall();
    end
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_write(input logic [imgrot_pkg::SRC_W-1:0] row,
                            input logic [imgrot_pkg::SRC_W-1:0] col,
                            input logic [imgrot_pkg::PIX_W-1:0] rgba);
    pix_beat_t b;
    b.kind    = imgrot_pkg::KIND_WRITE;
    b.src_row = row;
    b.src_col = col;
    b.out_row = imgrot_pkg::OUT_W'($urandom);
    b.out_col = imgrot_pkg::OUT_W'($urandom);
    b.rgba    = rgba;
    beats_pending.push_back(b);
    gen_written[{row, col}] = 1'b1;
    queued++;
  endtask

  task automatic push_read(input logic [imgrot_pkg::OUT_W-1:0] orow,
                           input logic [imgrot_pkg::OUT_W-1:0] ocol);
    pix_beat_t b;
    src_hit_t  hit;
    hit = rotate_lookup(orow, ocol);
    // a read may only land on an entry that already holds a pixel
    if (hit.landed && !gen_written[{hit.row, hit.col}])
      push_write(hit.row, hit.col, imgrot_pkg::PIX_W'($urandom));
    b.kind    = imgrot_pkg::KIND_READ;
    b.src_row = imgrot_pkg::SRC_W'($urandom);
    b.src_col = imgrot_pkg::SRC_W'($urandom);
    b.out_row = orow;
    b.out_col = ocol;
    b.rgba    = imgrot_pkg::PIX_W'($urandom);
    beats_pending.push_back(b);
    queued++;
  endtask

  // Wait until every beat went in and every result came out
  task automatic drain();
    do @(negedge clk);
    while (beats_pending.size() != 0 || in_valid || pixels_due.size() != 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // Write all four registers back to back; the block is idle here
  task automatic load_setup(input logic [imgrot_pkg::ANGLE_W-1:0] cv,
                            input logic [imgrot_pkg::ANGLE_W-1:0] sv,
                            input logic [imgrot_pkg::DIM_W-1:0] rv,
                            input logic [imgrot_pkg::DIM_W-1:0] colv);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= imgrot_pkg::REG_COS;
    cfg_wdata <= cv;
    cos_set    = cv;
    @(posedge clk);
    cfg_addr  <= imgrot_pkg::REG_SIN;
    cfg_wdata <= sv;
    sin_set    = sv;
    @(posedge clk);
    cfg_addr  <= imgrot_pkg::REG_ROWS;
    cfg_wdata <= {imgrot_pkg::DIM_W'($urandom), rv};
    rows_set   = rv;
    @(posedge clk);
    cfg_addr  <= imgrot_pkg::REG_COLS;
    cfg_wdata <= {imgrot_pkg::DIM_W'($urandom), colv};
    cols_set   = colv;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly small images, some full size, a few out-of-range values
  function automatic logic [imgrot_pkg::DIM_W-1:0] pick_dim();
    case ($urandom_range(19))
      0, 1:    return imgrot_pkg::DIM_W'(NROWS_MAX);
      2:       return imgrot_pkg::DIM_W'($urandom);
      3:       return imgrot_pkg::DIM_W'($urandom_range(NROWS_MAX, 1));
      default: return imgrot_pkg::DIM_W'($urandom_range(12, 1));
    endcase
  endfunction

  task automatic random_setup();
    logic [imgrot_pkg::ANGLE_W-1:0] cv, sv;
    case ($urandom_range(9))
      0:       begin cv = 16'sd16384;  sv = 16'sd0;      end
      1:       begin cv = 16'sd14189;  sv = 16'sd8192;   end
      2:       begin cv = 16'sd11585;  sv = 16'sd11585;  end
      3:       begin cv = 16'sd0;      sv = 16'sd16384;  end
      4:       begin cv = -16'sd11585; sv = 16'sd11585;  end
      5:       begin cv = -16'sd16384; sv = 16'sd0;      end
      6:       begin cv = 16'sd0;      sv = -16'sd16384; end
      7:       begin cv = 16'sd8192;   sv = -16'sd14189; end
      // arbitrary pair within the unit range
      8: begin
        cv = imgrot_pkg::ANGLE_W'(int'($urandom_range(32768)) - 16384);
        sv = imgrot_pkg::ANGLE_W'(int'($urandom_range(32768)) - 16384);
      end
      default: begin
        cv = imgrot_pkg::ANGLE_W'($urandom);
        sv = imgrot_pkg::ANGLE_W'($urandom);
      end
    endcase
    load_setup(cv, sv, pick_dim(), pick_dim());
  endtask

  // Raster scan of the rotated image, then random loads and reads
  task automatic fill_phase(input int unsigned target);
    src_hit_t    box;
    int unsigned start, n;
    int          r, c;
    box   = rotate_lookup('0, '0);
    start = queued;
    n     = 0;
    for (r = 0; r < int'(box.height) && n < RASTER_CAP; r++)
      for (c = 0; c < int'(box.width) && n < RASTER_CAP; c++) begin
        push_read(imgrot_pkg::OUT_W'(r), imgrot_pkg::OUT_W'(c));
        n++;
      end
    while (queued - start < target) begin
      case ($urandom_range(9))
        0, 1, 2:    push_write(imgrot_pkg::SRC_W'($urandom), imgrot_pkg::SRC_W'($urandom),
                               imgrot_pkg::PIX_W'($urandom));
        3, 4, 5, 6: push_read(imgrot_pkg::OUT_W'($urandom_range(int'(box.height) + 1)),
                              imgrot_pkg::OUT_W'($urandom_range(int'(box.width) + 1)));
        default:    push_read(imgrot_pkg::OUT_W'($urandom), imgrot_pkg::OUT_W'($urandom));
      endcase
    end
  endtask

  // Stimulus and end of run
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // identity out of reset: corners, outside positions, beyond the output size
    @(negedge clk);
    push_write('0, '0, '0);
    push_write('1, '1, '1);
    push_read(9'd0, 9'd0);
    push_read(9'd127, 9'd127);
    push_read(9'd127, 9'd0);
    push_read(9'd128, 9'd5);
    push_read(9'd511, 9'd511);
    push_read(9'd0, 9'd300);
    drain();

    // quarter turn on a 3 x 4 image, whole output in raster order
    load_setup(16'sd0, 16'sd16384, 8'd3, 8'd4);
    @(negedge clk);
    fill_phase(0);
    drain();

    // angles beyond the unit range, size registers beyond their range
    load_setup(16'h8000, 16'h7FFF, 8'd0, 8'd255);
    @(negedge clk);
    push_read(9'd0, 9'd0);
    push_read(9'd127, 9'd127);
    push_read(9'd511, 9'd0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      case (p)
        3:       load_setup(16'h8000, 16'h7FFF, 8'hFF, 8'd1);
        7:       load_setup(16'h7FFF, 16'h8000, 8'd0, 8'd128);
        10:      load_setup(16'sd11585, 16'sd11585, 8'd128, 8'd128);
        default: random_setup();
      endcase
      @(negedge clk);
      pace = (p < 4) ? PACE_SLOW_SINK : (p < 8) ? PACE_SLOW_SOURCE : PACE_FULL;
      if (p == 2) hold_go = 1'b1;
      fill_phase(PHASE_ITEMS);
    end

    drain();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
